### hdl/som_pkg.sv
// ----------------------------------------------------------------------------
// som_pkg
// Shared types and constants for the stripe offset mapper.
// ----------------------------------------------------------------------------
package som_pkg;

	localparam int unsigned OFFSET_BITS_DEF = 48;
	localparam int unsigned FUNC_W          = 2;
	localparam int unsigned STRIP_W         = 32;
	localparam int unsigned TOTAL_W         = 11;
	localparam int unsigned INDEX_W         = 10;
	localparam int unsigned CFG_IDX_W       = 2;

	localparam logic [STRIP_W-1:0] STRIP_RESET = 32'd65536;
	localparam logic [TOTAL_W-1:0] TOTAL_RESET = 11'd1;
	localparam logic [INDEX_W-1:0] INDEX_RESET = 10'd0;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STRIP_BYTES  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SERVER_TOTAL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SERVER_INDEX = 2'd2;

	typedef enum logic [FUNC_W-1:0] {
		FN_L2P  = 2'd0,
		FN_P2L  = 2'd1,
		FN_NEXT = 2'd2,
		FN_LEN  = 2'd3
	} func_t;

endpackage

### hdl/som_div_pipe.sv
// ----------------------------------------------------------------------------
// som_div_pipe
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module som_div_pipe #(
	parameter int unsigned DW = 48,
	parameter int unsigned VW = 32,
	parameter int unsigned SW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [DW-1:0] in_dvd,
	input  logic [VW-1:0] dvs,
	input  logic [SW-1:0] in_side,
	output logic          out_vld,
	output logic [DW-1:0] out_quo,
	output logic [VW-1:0] out_rem,
	output logic [SW-1:0] out_side
);

	// the user must hold the divisor static while transactions are in flight; the block does not enforce it
	logic          vld_s  [DW];
	logic [VW-1:0] rem_s  [DW];
	logic [DW-1:0] x_s    [DW];
	logic [SW-1:0] side_s [DW];

	for (genvar k = 0; k < DW; k++) begin : g_stage
		logic          vld_i;
		logic [VW-1:0] rem_i;
		logic [DW-1:0] x_i;
		logic [SW-1:0] side_i;
		logic [VW:0]   trial;
		logic [VW:0]   diff;
		logic          ge;

		if (k == 0) begin : g_first
			assign vld_i  = in_vld;
			assign rem_i  = '0;
			assign x_i    = in_dvd;
			assign side_i = in_side;
		end else begin : g_next
			assign vld_i  = vld_s[k-1];
			assign rem_i  = rem_s[k-1];
			assign x_i    = x_s[k-1];
			assign side_i = side_s[k-1];
		end

		assign trial = {rem_i, x_i[DW-1]};
		assign ge    = trial >= {1'b0, dvs};
		assign diff  = trial - {1'b0, dvs};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? diff[VW-1:0] : trial[VW-1:0];
				x_s[k]    <= {x_i[DW-2:0], ge};
				side_s[k] <= side_i;
			end
		end
	end

	assign out_vld  = vld_s[DW-1];
	assign out_quo  = x_s[DW-1];
	assign out_rem  = rem_s[DW-1];
	assign out_side = side_s[DW-1];

endmodule

### hdl/stripe_offset_mapper_core.sv
// ----------------------------------------------------------------------------
// stripe_offset_mapper_core
// Round-robin striping address map: four offset translations, pipelined.
// ----------------------------------------------------------------------------
// One transaction enters per clock and one result leaves per clock while the
// output is not stalled. Two bit-serial divider pipes run in series: offset /
// strip_bytes, then strip number / server_total, each one quotient bit per
// stage. Three front stages compute the server's first strip start and the
// dividend, four back stages select the multiplicand, form 32x32 partial
// products with strip_bytes and sum, saturating to all ones with overflow
// set. A stall at the output while a result is valid freezes the whole pipe.
// Configuration must only be written when the pipe is empty.
module stripe_offset_mapper_core #(
	parameter int unsigned OFFSET_BITS = som_pkg::OFFSET_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [som_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [som_pkg::STRIP_W-1:0]     cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  som_pkg::func_t                  func,
	input  logic [OFFSET_BITS-1:0]          offset_in,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [OFFSET_BITS-1:0]          offset_out,
	output logic                            overflow
);
	import som_pkg::*;

	localparam int unsigned W       = OFFSET_BITS;
	localparam int unsigned START_W = STRIP_W + INDEX_W;
	localparam int unsigned CMP_W   = (W > START_W) ? W : START_W;
	localparam int unsigned MW      = W + TOTAL_W;           // multiplicand
	localparam int unsigned NX_W    = W + 1;
	localparam int unsigned NCH     = (MW + STRIP_W - 1) / STRIP_W;
	localparam int unsigned MPAD_W  = NCH * STRIP_W;
	localparam int unsigned PROD_W  = 2 * STRIP_W;
	localparam int unsigned CC_W    = (W > STRIP_W + 1) ? W : STRIP_W + 1;
	localparam int unsigned SUM_W   = MPAD_W + STRIP_W + 1;
	localparam int unsigned SA_W    = FUNC_W + 1 + W;
	localparam int unsigned SB_W    = SA_W + STRIP_W + W;

	// ---------------- configuration ----------------
	logic [STRIP_W-1:0] strip_q;
	logic [TOTAL_W-1:0] total_q;
	logic [INDEX_W-1:0] index_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strip_q <= STRIP_RESET;
			total_q <= TOTAL_RESET;
			index_q <= INDEX_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_STRIP_BYTES:  strip_q <= cfg_wdata;
				REG_SERVER_TOTAL: total_q <= cfg_wdata[TOTAL_W-1:0];
				REG_SERVER_INDEX: index_q <= cfg_wdata[INDEX_W-1:0];
				default: ;
			endcase
		end
	end

	// zero strip / zero count act as one; index clamps to count-1
	logic [STRIP_W-1:0] s_eff;
	logic [TOTAL_W-1:0] t_eff;
	logic [TOTAL_W-1:0] t_m1;
	logic [INDEX_W-1:0] idx_eff;

	assign s_eff   = (strip_q == '0) ? STRIP_W'(1) : strip_q;
	assign t_eff   = (total_q == '0) ? TOTAL_W'(1) : total_q;
	assign t_m1    = t_eff - TOTAL_W'(1);
	assign idx_eff = ({1'b0, index_q} >= t_eff) ? t_m1[INDEX_W-1:0] : index_q;

	// ---------------- global pipe advance ----------------
	logic adv;
	assign in_stall = out_valid & out_stall;
	assign adv      = ~in_stall;

	// ---------------- stage 1: capture transaction ----------------
	logic         v_s1;
	func_t        func_s1;
	logic [W-1:0] off_s1;

	// ---------------- stage 2: first strip start of this server ----------
	logic               v_s2;
	func_t              func_s2;
	logic [W-1:0]       off_s2;
	logic [START_W-1:0] start_s2;

	// ---------------- stage 3: dividend ----------------
	logic         v_s3;
	func_t        func_s3;
	logic [W-1:0] off_s3;
	logic         lt_s3;
	logic [W-1:0] dvd_s3;

	logic [CMP_W-1:0] start_c;
	logic [W-1:0]     start_w;
	logic             lt_c;

	assign start_c = CMP_W'(start_s2);
	assign start_w = start_c[W-1:0];
	assign lt_c    = CMP_W'(off_s2) < start_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			func_s1  <= func;
			off_s1   <= offset_in;
			func_s2  <= func_s1;
			off_s2   <= off_s1;
			start_s2 <= START_W'(idx_eff) * START_W'(s_eff);
			func_s3  <= func_s2;
			off_s3   <= off_s2;
			lt_s3    <= lt_c;
			// next-mapped works on the distance from the first own strip
			dvd_s3   <= (func_s2 == FN_NEXT && !lt_c) ? off_s2 - start_w : off_s2;
		end
	end

	// ---------------- divider A: offset / strip ----------------
	logic                va;
	logic [W-1:0]        qa;
	logic [STRIP_W-1:0]  ra;
	logic [SA_W-1:0]     sa;

	som_div_pipe #(.DW(W), .VW(STRIP_W), .SW(SA_W)) u_div_strip (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (v_s3),
		.in_dvd   (dvd_s3),
		.dvs      (s_eff),
		.in_side  ({func_s3, lt_s3, off_s3}),
		.out_vld  (va),
		.out_quo  (qa),
		.out_rem  (ra),
		.out_side (sa)
	);

	// ---------------- divider B: strip number / servers ----------------
	logic               vb;
	logic [W-1:0]       qb;
	logic [TOTAL_W-1:0] rb;
	logic [SB_W-1:0]    sb;

	som_div_pipe #(.DW(W), .VW(TOTAL_W), .SW(SB_W)) u_div_total (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (va),
		.in_dvd   (qa),
		.dvs      (t_eff),
		.in_side  ({sa, ra, qa}),
		.out_vld  (vb),
		.out_quo  (qb),
		.out_rem  (rb),
		.out_side (sb)
	);

	logic [W-1:0]       qa_b;
	logic [STRIP_W-1:0] ra_b;
	logic [SA_W-1:0]    sa_b;
	func_t              func_b;
	logic               lt_b;
	logic [W-1:0]       off_b;

	assign qa_b   = sb[W-1:0];
	assign ra_b   = sb[W +: STRIP_W];
	assign sa_b   = sb[SB_W-1 -: SA_W];
	assign func_b = func_t'(sa_b[SA_W-1 -: FUNC_W]);
	assign lt_b   = sa_b[W];
	assign off_b  = sa_b[W-1:0];

	// ---------------- stage 4: strip products ----------------
	logic               v_s4;
	func_t              func_s4;
	logic               lt_s4;
	logic [W-1:0]       off_s4;
	logic [STRIP_W-1:0] r_s4;
	logic [W-1:0]       qb_s4;
	logic [MW-1:0]      mt_s4;   // strip number times servers
	logic [NX_W-1:0]    nx_s4;   // start strip of next full stripe
	logic               rb_nz_s4;

	// ---------------- stage 5: operand select ----------------
	logic          v_s5;
	logic [MW-1:0] m_s5;
	logic [CC_W-1:0] c_s5;
	logic [MW-1:0]   m_c;
	logic [CC_W-1:0] c_c;

	always_comb begin
		m_c = '0;
		c_c = '0;
		case (func_s4)
			FN_L2P: begin
				m_c = MW'(qb_s4);
				c_c = CC_W'(r_s4);
			end
			FN_P2L: begin
				m_c = mt_s4 + MW'(idx_eff);
				c_c = CC_W'(r_s4);
			end
			FN_NEXT: begin
				if (lt_s4) begin
					m_c = MW'(idx_eff);
				end else if (!rb_nz_s4) begin
					c_c = CC_W'(off_s4);
				end else begin
					m_c = MW'(nx_s4) + MW'(idx_eff);
				end
			end
			FN_LEN: begin
				c_c = CC_W'({1'b0, s_eff}) - CC_W'(r_s4);
			end
			default: begin
				m_c = '0;
				c_c = '0;
			end
		endcase
	end

	// ---------------- stage 6: partial products ----------------
	logic              v_s6;
	logic [PROD_W-1:0] pp_s6 [NCH];
	logic [CC_W-1:0]   c_s6;
	logic [MPAD_W-1:0] m_pad;

	assign m_pad = MPAD_W'(m_s5);

	// ---------------- stage 7: sum, saturate, output register ----------------
	logic [SUM_W-1:0] total;
	logic             ovf_c;

	always_comb begin
		total = SUM_W'(c_s6);
		for (int i = 0; i < NCH; i++) begin
			total = total + (SUM_W'(pp_s6[i]) << (STRIP_W * i));
		end
		ovf_c = |total[SUM_W-1:W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_s4      <= vb;
			v_s5      <= v_s4;
			v_s6      <= v_s5;
			out_valid <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			func_s4  <= func_b;
			lt_s4    <= lt_b;
			off_s4   <= off_b;
			r_s4     <= ra_b;
			qb_s4    <= qb;
			mt_s4    <= MW'(qa_b) * MW'(t_eff);
			nx_s4    <= NX_W'(qa_b) - NX_W'(rb) + NX_W'(t_eff);
			rb_nz_s4 <= (rb != '0);
			m_s5     <= m_c;
			c_s5     <= c_c;
			for (int i = 0; i < NCH; i++) begin
				pp_s6[i] <= PROD_W'(m_pad[i*STRIP_W +: STRIP_W]) * PROD_W'(s_eff);
			end
			c_s6       <= c_s5;
			offset_out <= ovf_c ? '1 : total[W-1:0];
			overflow   <= ovf_c;
		end
	end

	// ---------------- assertions ----------------
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> offset_out == '1)
		else $error("overflow without saturated offset");

	a_idx_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, idx_eff} < t_eff)
		else $error("effective server index not below server count");

	a_strip_nz: assert property (@(posedge clk) disable iff (!arst_n)
		s_eff != '0 && t_eff != '0)
		else $error("zero divisor reached the divider pipes");

endmodule

### tb/tb_stripe_offset_mapper_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stripe_offset_mapper_core
// Self-checking bench for the striping offset mapper. A behavioral
// translator predicts every transaction; results are matched in order
// against it while both handshake sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_stripe_offset_mapper_core;
	import som_pkg::*;

	localparam int unsigned OB = OFFSET_BITS_DEF;
	localparam int unsigned LATENCY = 2*OB + 7;
	localparam int unsigned IDLE_LIMIT = 20000;
	localparam logic [OB-1:0] OMAX = {OB{1'b1}};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [STRIP_W-1:0] cfg_wdata;
	logic in_valid;
	logic in_stall;
	func_t func;
	logic [OB-1:0] offset_in;
	logic out_valid;
	logic out_stall;
	logic [OB-1:0] offset_out;
	logic overflow;

	typedef struct packed {
		logic [OB-1:0] offset;
		logic ovf;
	} mapping_t;

	// shadow copy of the configuration registers
	logic [STRIP_W-1:0] sh_strip;
	logic [TOTAL_W-1:0] sh_total;
	logic [INDEX_W-1:0] sh_index;

	mapping_t pending_maps[$];
	int errors;
	int idle_cycles;
	int stall_mode;
	int burst_left;

	stripe_offset_mapper_core #(.OFFSET_BITS(OB)) uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .offset_in(offset_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.offset_out(offset_out), .overflow(overflow)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Translate one offset with the current shadow configuration.
	// Arithmetic in 128 bits so no intermediate can wrap.
	function automatic mapping_t map_offset(func_t f, logic [OB-1:0] off);
		logic [127:0] s, t, idx, q, r, v, lstrip, start, stripe, diff;
		mapping_t m;
		s = (sh_strip == 0) ? 128'd1 : 128'(sh_strip);
		t = (sh_total == 0) ? 128'd1 : 128'(sh_total);
		idx = (128'(sh_index) >= t) ? t - 1 : 128'(sh_index);
		q = 128'(off) / s;
		r = 128'(off) % s;
		case (f)
			FN_L2P: v = (q / t) * s + r;
			FN_P2L: begin
				lstrip = q * t + idx;
				v = lstrip * s + r;
			end
			FN_NEXT: begin
				start = idx * s;
				stripe = t * s;
				if (128'(off) < start) begin
					v = start;
				end else begin
					diff = (128'(off) - start) % stripe;
					v = (diff >= s) ? 128'(off) + (stripe - diff) : 128'(off);
				end
			end
			default: v = s - r;
		endcase
		if (v > 128'(OMAX)) begin
			m.offset = OMAX;
			m.ovf = 1'b1;
		end else begin
			m.offset = v[OB-1:0];
			m.ovf = 1'b0;
		end
		return m;
	endfunction

	// One transaction; sender gap bursts come from burst_left.
	// valid stays high into the next call so items can follow back to back.
	task automatic send_item(func_t f, logic [OB-1:0] off);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 2) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		func <= f;
		offset_in <= off;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_maps.push_back(map_offset(f, off));
		@(negedge clk);
	endtask

	// Register write, only with the pipe drained.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [STRIP_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_STRIP_BYTES: sh_strip = val;
			REG_SERVER_TOTAL: sh_total = val[TOTAL_W-1:0];
			REG_SERVER_INDEX: sh_index = val[INDEX_W-1:0];
			default: ;
		endcase
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (pending_maps.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic set_layout(logic [STRIP_W-1:0] s, logic [STRIP_W-1:0] t,
			logic [STRIP_W-1:0] i);
		drain();
		write_reg(REG_STRIP_BYTES, s);
		write_reg(REG_SERVER_TOTAL, t);
		write_reg(REG_SERVER_INDEX, i);
	endtask

	function automatic logic [OB-1:0] rand_off();
		logic [OB-1:0] o;
		o = OB'({$urandom, $urandom});
		case ($urandom_range(0, 3))
			0: o = o & 48'hFFFFF;
			1: o = o & 48'hFFFFFFFF;
			2: o = OMAX - (o & 48'hFFFF);
			default: ;
		endcase
		return o;
	endfunction

	// Directed: extremes of the fields, all functions, the odd register values.
	task automatic test_directed;
		func_t f;
		set_layout(STRIP_RESET, STRIP_W'(TOTAL_RESET), STRIP_W'(INDEX_RESET));
		for (int k = 0; k < 4; k++) begin
			f = func_t'(k);
			send_item(f, '0);
			send_item(f, OMAX);
		end
		// zero strip size and zero server count act as one
		set_layout(32'd0, 32'd0, 32'd5);
		send_item(FN_L2P, 48'h123456789A);
		send_item(FN_P2L, OMAX);
		send_item(FN_LEN, 48'd77);
		// last index of a full server count; physical to logical overflow
		set_layout(32'hFFFFFFFF, 32'd1024, 32'd1023);
		send_item(FN_P2L, OMAX);
		send_item(FN_P2L, 48'h0);
		send_item(FN_NEXT, 48'd10);
		send_item(FN_NEXT, OMAX);
		send_item(FN_LEN, 48'hFFFFFFFF);
		set_layout(32'd4096, 32'd3, 32'd7);
		send_item(FN_NEXT, 48'd0);
		send_item(FN_NEXT, 48'd8192);
		send_item(FN_NEXT, 48'd12288);
		send_item(FN_L2P, 48'd20000);
		send_item(FN_P2L, 48'd5000);
		send_item(FN_LEN, 48'd4095);
	endtask

	// Random layouts, each followed by a run of random translations.
	task automatic test_random;
		logic [STRIP_W-1:0] s;
		for (int ph = 0; ph < 17; ph++) begin
			case ($urandom_range(0, 3))
				0: s = $urandom_range(1, 16);
				1: s = $urandom_range(1, 1 << 20);
				2: s = $urandom;
				default: s = 32'hFFFFFFFF - $urandom_range(0, 3);
			endcase
			set_layout(s, $urandom_range(0, 2047), $urandom_range(0, 1023));
			repeat (50)
				send_item(func_t'($urandom_range(0, 3)), rand_off());
		end
	endtask

	// receiver: stall pattern changes mode now and then, including no stalls
	always @(negedge clk) begin
		if ($urandom_range(0, 63) == 0)
			stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 1) == 0);
			default: out_stall <= ($urandom_range(0, 7) != 0);
		endcase
	end

	// result checker and idle watchdog
	always @(posedge clk) begin
		mapping_t exp_map;
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles > IDLE_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
			if (out_valid && !out_stall) begin
				if (pending_maps.size() == 0) begin
					$error("unexpected result offset_out=%h", offset_out);
					errors++;
				end else begin
					exp_map = pending_maps.pop_front();
					if (offset_out !== exp_map.offset) begin
						$error("offset_out expected %h actual %h", exp_map.offset,
							offset_out);
						errors++;
					end
					if (overflow !== exp_map.ovf) begin
						$error("overflow expected %b actual %b", exp_map.ovf, overflow);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		errors = 0;
		idle_cycles = 0;
		stall_mode = 0;
		burst_left = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_STRIP_BYTES;
		cfg_wdata = '0;
		in_valid = 1'b0;
		func = FN_L2P;
		offset_in = '0;
		out_stall = 1'b0;
		sh_strip = STRIP_RESET;
		sh_total = TOTAL_RESET;
		sh_index = INDEX_RESET;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random();
		drain();
		if (errors == 0 && pending_maps.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### sim.f
hdl/som_pkg.sv
hdl/som_div_pipe.sv
hdl/stripe_offset_mapper_core.sv
tb/tb_stripe_offset_mapper_core.sv
